// ----- rtl/core/qts_pkg.sv -----
// Shared constants for the quoted token splitter.
package qts_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned LEN_W  = 8;

  localparam logic [CHAR_W-1:0] END_CODE   = 8'h00;
  localparam logic [CHAR_W-1:0] QUOTE_CODE = 8'h22;
  localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;

endpackage

// ----- rtl/core/quoted_token_splitter_unit.sv -----
// Top level of the quoted token splitter: tokenizer state machine and result register.
// The block splits a character stream into whitespace-separated tokens, one character per
// transfer and one result per character, with double-quoted tokens in which a doubled quote
// stands for a literal quote. Code 0 ends the text. Every byte from 1 to 32 counts as
// whitespace, and bytes beyond MAX_TOKEN_LEN in a token are dropped. A character is taken in
// every cycle unless the output stalls; the tokenizer state and the result register update
// at the transfer, and the result appears in the next cycle. The single result register is
// the only buffering, so the input is ready when it is empty or its result is being taken.
module quoted_token_splitter_unit
  import qts_pkg::*;
#(
  parameter int unsigned MAX_TOKEN_LEN = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_char_code,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_token_ended,
  output logic              out_byte_valid,
  output logic [CHAR_W-1:0] out_byte,
  output logic              out_text_ended
);

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_OPENED,
    MODE_INSIDE,
    MODE_CLOSED
  } mode_t;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TOKEN_LEN);

  mode_t             mode_r, mode_nxt;
  logic              skip_r, skip_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              out_valid_r;
  logic              ended_r, ended_nxt;
  logic              bvalid_r, bvalid_nxt;
  logic [CHAR_W-1:0] byte_r, byte_nxt;
  logic              tend_r, tend_nxt;

  logic              in_xfer;
  logic              is_quote;
  logic              normal_pass;
  logic              append;
  logic              skip_base;
  logic [LEN_W-1:0]  len_base;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign is_quote = (in_char_code == QUOTE_CODE);

  always_comb begin
    mode_nxt    = mode_r;
    skip_nxt    = skip_r;
    len_nxt     = len_r;
    ended_nxt   = 1'b0;
    bvalid_nxt  = 1'b0;
    byte_nxt    = '0;
    tend_nxt    = 1'b0;
    normal_pass = 1'b0;
    append      = 1'b0;
    skip_base   = skip_r;
    len_base    = len_r;
    if (in_char_code == END_CODE) begin
      tend_nxt = 1'b1;
      mode_nxt = MODE_NORMAL;
      skip_nxt = 1'b1;
      len_nxt  = '0;
    end else begin
      unique case (mode_r)
        MODE_OPENED: begin
          append   = 1'b1;
          mode_nxt = is_quote ? MODE_NORMAL : MODE_INSIDE;
        end
        MODE_INSIDE: begin
          if (is_quote) begin
            mode_nxt = MODE_CLOSED;
          end else begin
            append = 1'b1;
          end
        end
        MODE_CLOSED: begin
          if (is_quote) begin
            append   = 1'b1;
            mode_nxt = MODE_INSIDE;
          end else begin
            ended_nxt   = 1'b1;
            mode_nxt    = MODE_NORMAL;
            skip_base   = 1'b1;
            len_base    = '0;
            skip_nxt    = 1'b1;
            len_nxt     = '0;
            normal_pass = 1'b1;
          end
        end
        default: begin
          normal_pass = 1'b1;
        end
      endcase
      if (normal_pass) begin
        if (is_quote) begin
          skip_nxt = 1'b0;
          mode_nxt = MODE_OPENED;
        end else if (in_char_code > SPACE_CODE) begin
          skip_nxt = 1'b0;
          append   = 1'b1;
        end else if (!skip_base) begin
          ended_nxt = 1'b1;
          mode_nxt  = MODE_NORMAL;
          skip_nxt  = 1'b1;
          len_nxt   = '0;
        end
      end
      if (append && (len_base < MAX_LEN)) begin
        bvalid_nxt = 1'b1;
        byte_nxt   = in_char_code;
        len_nxt    = len_base + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_NORMAL;
      skip_r      <= 1'b1;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        mode_r      <= mode_nxt;
        skip_r      <= skip_nxt;
        len_r       <= len_nxt;
        out_valid_r <= 1'b1;
        ended_r     <= ended_nxt;
        bvalid_r    <= bvalid_nxt;
        byte_r      <= byte_nxt;
        tend_r      <= tend_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_token_ended = ended_r;
  assign out_byte_valid  = bvalid_r;
  assign out_byte        = byte_r;
  assign out_text_ended  = tend_r;

endmodule

// ----- rtl/core/qts_checker.sv -----
// Port-level assertions for the quoted token splitter, bound to its top level.
module qts_checker
  import qts_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [CHAR_W-1:0] in_char_code,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_token_ended,
  input logic              out_byte_valid,
  input logic [CHAR_W-1:0] out_byte,
  input logic              out_text_ended
);

  // The end of the text produces a result of its own in the next cycle.
  a_end_result : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_char_code == END_CODE) |=> (out_valid && out_text_ended))
    else $error("end of text did not give a text_ended result");

  // An end-of-text result carries neither a token end nor a byte.
  a_end_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_text_ended) |-> (!out_token_ended && !out_byte_valid))
    else $error("text_ended result carries token data");

  // An appended byte is the character of the transfer that caused it.
  a_byte_source : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=>
      (out_valid && (!out_byte_valid || out_byte == $past(in_char_code))))
    else $error("appended byte differs from its character");

  // A quote either appends itself or nothing.
  a_quote_byte : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_char_code == QUOTE_CODE) |=>
      (!out_byte_valid || out_byte == QUOTE_CODE))
    else $error("quote produced a different byte");

  // A stalled result stays put.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(out_byte_valid)))
    else $error("stalled result changed");

endmodule

bind quoted_token_splitter_unit qts_checker u_qts_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_char_code    (in_char_code),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_token_ended (out_token_ended),
  .out_byte_valid  (out_byte_valid),
  .out_byte        (out_byte),
  .out_text_ended  (out_text_ended)
);
